[sv/tbeq_pkg.sv]
// Package for the three-band equalizer: fixed-point widths, register map,
// microcode field codes and the sequencer program ROM.
// No dependencies.
package tbeq_pkg;

  // Fixed-point format of samples, poles, gains and coefficients
  localparam int FRACTION_BITS = 28;
  localparam int WORD_W        = 32;
  localparam int COEF_W        = 30;
  localparam int SAMPLE_W      = 16;
  localparam int SCALE_SHIFT   = FRACTION_BITS - (SAMPLE_W - 1);

  // Multiplier: 33-bit signed operand times 32-bit signed difference
  localparam int MUL_A_W  = WORD_W + 1;
  localparam int MUL_RAW  = MUL_A_W + WORD_W;
  localparam int MUL_W    = (MUL_RAW > FRACTION_BITS + WORD_W) ? MUL_RAW
                                                               : FRACTION_BITS + WORD_W;

  // Output scaling: sum * 32767 held in OUT_W bits
  localparam int OUT_W = WORD_W + SAMPLE_W;

  localparam logic [63:0]       ONE_WIDE = 64'd1 << FRACTION_BITS;
  localparam logic [WORD_W-1:0] GAIN_ONE = ONE_WIDE[WORD_W-1:0];

  // Register map, index = paddr / 4
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_LOW_COEF  = 3'd0;
  localparam logic [2:0] REG_HIGH_COEF = 3'd1;
  localparam logic [2:0] REG_LOW_GAIN  = 3'd2;
  localparam logic [2:0] REG_MID_GAIN  = 3'd3;
  localparam logic [2:0] REG_HIGH_GAIN = 3'd4;

  // Difference unit operations
  localparam logic [2:0] D_NONE = 3'd0;
  localparam logic [2:0] D_SECT = 3'd1;  // cascade input minus pole
  localparam logic [2:0] D_LOW  = 3'd2;  // low band
  localparam logic [2:0] D_MID  = 3'd3;  // mid band
  localparam logic [2:0] D_HIGH = 3'd4;  // high band

  // Multiplier operand select
  localparam logic [2:0] M_NONE = 3'd0;
  localparam logic [2:0] M_CLO  = 3'd1;
  localparam logic [2:0] M_CHI  = 3'd2;
  localparam logic [2:0] M_GLO  = 3'd3;
  localparam logic [2:0] M_GMID = 3'd4;
  localparam logic [2:0] M_GHI  = 3'd5;

  // Accumulator operations
  localparam logic [1:0] A_NONE = 2'd0;
  localparam logic [1:0] A_LOAD = 2'd1;
  localparam logic [1:0] A_ADD  = 2'd2;

  // Sequencer jumps
  localparam logic [1:0] J_NEXT     = 2'd0;
  localparam logic [1:0] J_WAIT_IN  = 2'd1;  // hold until a word is taken in
  localparam logic [1:0] J_WAIT_OUT = 2'd2;  // hold until the output is free, then restart

  // Pole indexes: bit 2 selects the high cascade
  localparam logic [2:0] POLE_L0 = 3'd0;
  localparam logic [2:0] POLE_L1 = 3'd1;
  localparam logic [2:0] POLE_L2 = 3'd2;
  localparam logic [2:0] POLE_L3 = 3'd3;
  localparam logic [2:0] POLE_H0 = 3'd4;
  localparam logic [2:0] POLE_H1 = 3'd5;
  localparam logic [2:0] POLE_H2 = 3'd6;
  localparam logic [2:0] POLE_H3 = 3'd7;

  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd19;

  typedef struct packed {
    logic [2:0] dop;
    logic [2:0] dsel;
    logic [2:0] mop;
    logic       uen;
    logic [2:0] usel;
    logic [1:0] aop;
    logic       prod_en;
    logic [1:0] jmp;
  } ucode_t;

  // Program: low and high sections interleaved, three steps per section
  // (difference, multiply, update), then the gain products and the sum.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      5'd0:  w.jmp = J_WAIT_IN;
      5'd1:  begin w.dop = D_SECT; w.dsel = POLE_L0; end
      5'd2:  begin w.mop = M_CLO; w.dop = D_SECT; w.dsel = POLE_H0; end
      5'd3:  begin w.uen = 1'b1; w.usel = POLE_L0; w.mop = M_CHI; end
      5'd4:  begin w.uen = 1'b1; w.usel = POLE_H0; w.dop = D_SECT; w.dsel = POLE_L1; end
      5'd5:  begin w.mop = M_CLO; w.dop = D_SECT; w.dsel = POLE_H1; end
      5'd6:  begin w.uen = 1'b1; w.usel = POLE_L1; w.mop = M_CHI; end
      5'd7:  begin w.uen = 1'b1; w.usel = POLE_H1; w.dop = D_SECT; w.dsel = POLE_L2; end
      5'd8:  begin w.mop = M_CLO; w.dop = D_SECT; w.dsel = POLE_H2; end
      5'd9:  begin w.uen = 1'b1; w.usel = POLE_L2; w.mop = M_CHI; end
      5'd10: begin w.uen = 1'b1; w.usel = POLE_H2; w.dop = D_SECT; w.dsel = POLE_L3; end
      5'd11: begin w.mop = M_CLO; w.dop = D_SECT; w.dsel = POLE_H3; end
      5'd12: begin w.uen = 1'b1; w.usel = POLE_L3; w.mop = M_CHI; end
      5'd13: begin w.uen = 1'b1; w.usel = POLE_H3; w.dop = D_LOW; end
      5'd14: begin w.mop = M_GLO; w.dop = D_MID; end
      5'd15: begin w.aop = A_LOAD; w.mop = M_GMID; w.dop = D_HIGH; end
      5'd16: begin w.aop = A_ADD; w.mop = M_GHI; end
      5'd17: w.aop = A_ADD;
      5'd18: w.prod_en = 1'b1;
      5'd19: w.jmp = J_WAIT_OUT;
      default: w.jmp = J_WAIT_OUT;
    endcase
    return w;
  endfunction

endpackage

[sv/three_band_audio_equalizer.sv]
// Three-band equalizer, four-pole crossover: sequencer, datapath, APB registers.
// An input word is taken only at step 0 and its result is registered at the last step,
//   so the 20-step program, which shares one 33x32 multiplier, runs once per word;
//   the last step holds while the output is stalled.
// Reset clears poles, sample history and output valid; gains return to unity,
//   coefficients to zero. Depends on tbeq_pkg.
module three_band_audio_equalizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] left_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] left_out_o,
  output logic [15:0] right_out_o,
  output logic        clipped_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tbeq_pkg::*;

  localparam logic signed [OUT_W-1:0] SAT_HI = OUT_W'(32767);
  localparam logic signed [OUT_W-1:0] SAT_LO = -OUT_W'(32768);
  localparam logic [OUT_W-1:0] TRUNC_BIAS = {{(OUT_W-FRACTION_BITS){1'b0}},
                                             {FRACTION_BITS{1'b1}}};

  // Configuration registers
  logic [COEF_W-1:0] low_coef_q, high_coef_q;
  logic [WORD_W-1:0] low_gain_q, mid_gain_q, high_gain_q;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  // Sequencer
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uc;
  logic              in_accept, out_free, emit;

  // Datapath
  logic [WORD_W-1:0] poles_q [8];
  logic [WORD_W-1:0] hist_q [3];
  logic [WORD_W-1:0] xl_q, xh_q, pl_q, ph_q, s_q, d_q, m_q, acc_q;
  logic [WORD_W-1:0] scaled, diff, pole_new, p_sel;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_W-1:0]   mul_full;
  logic [OUT_W-1:0]   prod_q, acc_ext, biased;
  logic signed [OUT_W-1:0] quot;
  logic [15:0]        res;
  logic               clip;
  logic               out_valid_q, clip_q;
  logic [15:0]        out_q;

  // APB register port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_coef_q  <= '0;
      high_coef_q <= '0;
      low_gain_q  <= GAIN_ONE;
      mid_gain_q  <= GAIN_ONE;
      high_gain_q <= GAIN_ONE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LOW_COEF:  low_coef_q  <= pwdata[COEF_W-1:0];
        REG_HIGH_COEF: high_coef_q <= pwdata[COEF_W-1:0];
        REG_LOW_GAIN:  low_gain_q  <= pwdata;
        REG_MID_GAIN:  mid_gain_q  <= pwdata;
        REG_HIGH_GAIN: high_gain_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LOW_COEF:  prdata = {{(32-COEF_W){1'b0}}, low_coef_q};
      REG_HIGH_COEF: prdata = {{(32-COEF_W){1'b0}}, high_coef_q};
      REG_LOW_GAIN:  prdata = low_gain_q;
      REG_MID_GAIN:  prdata = mid_gain_q;
      REG_HIGH_GAIN: prdata = high_gain_q;
      default:       prdata = '0;
    endcase
  end

  // Step counter and jumps
  assign uc         = ucode_rom(step_q);
  assign in_stall_o = (step_q != '0);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (uc.jmp == J_WAIT_OUT) && out_free;

  always_comb begin
    step_d = step_q;
    unique case (uc.jmp)
      J_WAIT_IN:  if (in_accept) step_d = step_q + 1'b1;
      J_WAIT_OUT: if (out_free) step_d = '0;
      default:    step_d = step_q + 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= '0;
    else         step_q <= step_d;
  end

  // Input scaling to Q format, wraps to 32 bits
  assign scaled = WORD_W'($signed(left_sample_i)) << SCALE_SHIFT;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      xl_q <= scaled;
      xh_q <= scaled;
      s_q  <= scaled;
    end else if (uc.uen) begin
      if (uc.usel[2]) xh_q <= pole_new;
      else            xl_q <= pole_new;
    end
  end

  // Difference unit
  always_comb begin
    unique case (uc.dop)
      D_SECT:  diff = (uc.dsel[2] ? xh_q : xl_q) - poles_q[uc.dsel];
      D_LOW:   diff = poles_q[POLE_L3];
      D_MID:   diff = poles_q[POLE_H3] - poles_q[POLE_L3];
      D_HIGH:  diff = hist_q[2] - poles_q[POLE_H3];
      default: diff = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (uc.dop != D_NONE) d_q <= diff;
    if (uc.dop == D_SECT) begin
      if (uc.dsel[2]) ph_q <= poles_q[uc.dsel];
      else            pl_q <= poles_q[uc.dsel];
    end
  end

  // Shared multiplier, floor shift by the fraction width
  always_comb begin
    unique case (uc.mop)
      M_CLO:   mul_a = {{(MUL_A_W-COEF_W){1'b0}}, low_coef_q};
      M_CHI:   mul_a = {{(MUL_A_W-COEF_W){1'b0}}, high_coef_q};
      M_GLO:   mul_a = {low_gain_q[WORD_W-1], low_gain_q};
      M_GMID:  mul_a = {mid_gain_q[WORD_W-1], mid_gain_q};
      M_GHI:   mul_a = {high_gain_q[WORD_W-1], high_gain_q};
      default: mul_a = '0;
    endcase
  end

  assign mul_full = MUL_W'($signed(mul_a) * $signed(d_q));

  always_ff @(posedge clk_i) begin
    if (uc.mop != M_NONE) m_q <= mul_full[FRACTION_BITS +: WORD_W];
  end

  // Pole update
  assign p_sel    = uc.usel[2] ? ph_q : pl_q;
  assign pole_new = p_sel + m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) poles_q[i] <= '0;
      for (int i = 0; i < 3; i++) hist_q[i] <= '0;
    end else begin
      if (uc.uen) poles_q[uc.usel] <= pole_new;
      if (emit) begin
        hist_q[2] <= hist_q[1];
        hist_q[1] <= hist_q[0];
        hist_q[0] <= s_q;
      end
    end
  end

  // Band sum and times 32767
  assign acc_ext = OUT_W'($signed(acc_q));

  always_ff @(posedge clk_i) begin
    unique case (uc.aop)
      A_LOAD:  acc_q <= m_q;
      A_ADD:   acc_q <= acc_q + m_q;
      default: ;
    endcase
    if (uc.prod_en) prod_q <= (acc_ext << 15) - acc_ext;
  end

  // Truncate toward zero, saturate to int16
  assign biased = prod_q + (prod_q[OUT_W-1] ? TRUNC_BIAS : '0);
  assign quot   = $signed(biased) >>> FRACTION_BITS;

  always_comb begin
    if (quot > SAT_HI) begin
      res  = 16'h7fff;
      clip = 1'b1;
    end else if (quot < SAT_LO) begin
      res  = 16'h8000;
      clip = 1'b1;
    end else begin
      res  = quot[15:0];
      clip = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          out_valid_q <= 1'b0;
    else if (emit)        out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q  <= res;
      clip_q <= clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_q;
  assign right_out_o = out_q;
  assign clipped_o   = clip_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> step_q == 5'd1) else $error("accept did not start program");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LAST_STEP) else $error("step counter out of range");

  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == LAST_STEP)
    else $error("result raised outside last step");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == LAST_STEP && out_valid_q && out_stall_i) |=> step_q == LAST_STEP)
    else $error("sequencer left last step while output stalled");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the three-band equalizer: directed and random sample
// words, APB register settings, a cycle-free predictor and randomized idling.
// Depends on tbeq_pkg and three_band_audio_equalizer.
module tb;
  import tbeq_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int LATENCY_PAD    = 24;
  localparam int DRAIN_LIMIT    = 4000;
  localparam int TIMEOUT_CYCLES = 400_000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_WORDS    = 188;
  localparam int QUIET_PHASE    = 3;
  localparam int HOLD_PHASE     = 5;
  localparam int HOLD_AT_WORD   = 60;
  localparam int HOLD_CYCLES    = 90;
  localparam int LOW_BANK       = 0;
  localparam int HIGH_BANK      = 1;

  localparam logic [29:0] COEF_MAX = 30'h2000_0000;
  localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] GAIN_MIN = 32'h8000_0000;
  localparam logic [31:0] GAIN_OFF = 32'h0000_0000;

  typedef struct packed {
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic        clipped;
  } eq_word_t;

  // One directed sample; gains are rewritten before it when set_gains is high
  typedef struct packed {
    logic        set_gains;
    logic [31:0] gains;
    logic [15:0] sample;
    logic        known;
    logic [15:0] out_val;
    logic        out_clip;
  } stim_row_t;

  // Coefficients stay zero here, so each output is the sample three words back
  // times the gain, times 32767/32768, truncated toward zero and saturated.
  localparam stim_row_t DIRECTED [22] = '{
    '{1'b0, GAIN_OFF, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'h8000, 1'b1, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'h0001, 1'b1, 16'h7FFE, 1'b0},
    '{1'b0, GAIN_OFF, 16'hFFFF, 1'b1, 16'h8001, 1'b0},
    '{1'b0, GAIN_OFF, 16'h5555, 1'b1, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'hAAAA, 1'b1, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'h0064, 1'b1, 16'h0000, 1'b0},  // -1 truncates to 0
    '{1'b0, GAIN_OFF, 16'hFF9C, 1'b1, 16'h5554, 1'b0},
    '{1'b0, GAIN_OFF, 16'h7FFF, 1'b1, 16'hAAAB, 1'b0},
    '{1'b0, GAIN_OFF, 16'h8000, 1'b1, 16'h0063, 1'b0},
    '{1'b0, GAIN_OFF, 16'h7FFF, 1'b1, 16'hFF9D, 1'b0},
    // largest gains: both rails saturate
    '{1'b1, GAIN_MAX, 16'h8000, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, GAIN_OFF, 16'h0000, 1'b1, 16'h8000, 1'b1},
    '{1'b0, GAIN_OFF, 16'h8000, 1'b1, 16'h7FFF, 1'b1},
    '{1'b0, GAIN_OFF, 16'h0001, 1'b1, 16'h8000, 1'b1},
    // most negative gains: full-scale negative input wraps the band product
    '{1'b1, GAIN_MIN, 16'h7FFF, 1'b1, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    // zero gains mute everything
    '{1'b1, GAIN_OFF, 16'h3039, 1'b1, 16'h0000, 1'b0},
    '{1'b0, GAIN_OFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] left_sample_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] left_out_o;
  logic [15:0] right_out_o;
  logic        clipped_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and register copy
  logic [29:0] low_coef_q;
  logic [29:0] high_coef_q;
  int          low_gain_q;
  int          mid_gain_q;
  int          high_gain_q;
  int          pole_q [2][4];
  int          delay_q [3];

  eq_word_t    pending_words [$];
  int          error_count    = 0;
  int          words_sent     = 0;
  int          words_checked  = 0;
  int          clipped_seen   = 0;
  int          src_idle_pct   = 0;
  int          sink_stall_pct = 0;
  bit          hold_req       = 1'b0;

  three_band_audio_equalizer uut (.*);

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Fixed-point product, floored to the fraction grid, wrapped to 32 bits
  function automatic int fx_mul(input longint a, input longint b);
    return int'((a * b) >>> FRACTION_BITS);
  endfunction

  // Four one-pole sections in series; int arithmetic wraps like the datapath
  function automatic void run_cascade(input int bank, input longint coef, input int x);
    int diff;
    for (int i = 0; i < 4; i++) begin
      diff = x - pole_q[bank][i];
      pole_q[bank][i] = pole_q[bank][i] + fx_mul(coef, diff);
      x = pole_q[bank][i];
    end
  endfunction

  // Advance the filter state by one sample and return the equalized word
  function automatic eq_word_t equalize_word(input logic [15:0] smp);
    int       scaled;
    int       low_band;
    int       mid_band;
    int       high_band;
    int       sum;
    longint   prod;
    longint   outv;
    eq_word_t r;
    scaled = int'(longint'($signed(smp)) <<< SCALE_SHIFT);
    run_cascade(LOW_BANK, longint'(low_coef_q), scaled);
    run_cascade(HIGH_BANK, longint'(high_coef_q), scaled);
    low_band  = pole_q[LOW_BANK][3];
    high_band = delay_q[2] - pole_q[HIGH_BANK][3];
    mid_band  = delay_q[2] - (high_band + low_band);
    low_band  = fx_mul(low_band, low_gain_q);
    mid_band  = fx_mul(mid_band, mid_gain_q);
    high_band = fx_mul(high_band, high_gain_q);
    delay_q[2] = delay_q[1];
    delay_q[1] = delay_q[0];
    delay_q[0] = scaled;
    sum  = low_band + mid_band + high_band;
    prod = longint'(sum) * 32767;
    // truncate toward zero, then saturate to int16
    if (prod < 0) outv = -((-prod) >>> FRACTION_BITS);
    else outv = prod >>> FRACTION_BITS;
    r.clipped = 1'b0;
    if (outv > 32767) begin
      outv = 32767;
      r.clipped = 1'b1;
    end else if (outv < -32768) begin
      outv = -32768;
      r.clipped = 1'b1;
    end
    r.left_out  = outv[15:0];
    r.right_out = outv[15:0];
    return r;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [31:0] data);
    case (idx)
      REG_LOW_COEF:  low_coef_q  = data[29:0];
      REG_HIGH_COEF: high_coef_q = data[29:0];
      REG_LOW_GAIN:  low_gain_q  = int'(data);
      REG_MID_GAIN:  mid_gain_q  = int'(data);
      REG_HIGH_GAIN: high_gain_q = int'(data);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_LOW_COEF:  return {2'b00, low_coef_q};
      REG_HIGH_COEF: return {2'b00, high_coef_q};
      REG_LOW_GAIN:  return low_gain_q;
      REG_MID_GAIN:  return mid_gain_q;
      REG_HIGH_GAIN: return high_gain_q;
      default:       return '0;
    endcase
  endfunction

  // Half the time a realistic crossover, otherwise anywhere up to 2.0
  function automatic logic [31:0] rand_coef();
    if ($urandom_range(1, 0) == 0) return $urandom_range(32'h0400_0000, 0);
    return $urandom_range(32'h2000_0000, 0);
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(3, 0))
      0:       return $urandom();
      3:       return GAIN_ONE;
      default: return $urandom_range(32'h4000_0000, 0) - 32'h2000_0000;
    endcase
  endfunction

  // APB write: setup, access, register taken on the access edge
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    store_reg(idx, data);
  endtask

  // APB read: prdata sampled mid-cycle during the access phase
  task automatic apb_read(input logic [2:0] idx, output logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    data = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    logic [31:0] rd;
    for (int i = REG_LOW_COEF; i <= REG_HIGH_GAIN; i++) begin
      apb_read(i[2:0], rd);
      if (rd !== reg_value(i[2:0])) begin
        $error("register %0d readback: expected %h, actual %h", i, reg_value(i[2:0]), rd);
        error_count++;
      end
    end
  endtask

  // Stop offering, hold off until every expected word has come out, then settle
  task automatic wait_drained();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_words.size() != 0) begin
      $error("%0d expected words never came out", pending_words.size());
      error_count++;
    end
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  // Offer one sample word; the expectation is queued on the accepting edge
  task automatic send_sample(input logic [15:0] smp, input bit use_typed,
                             input eq_word_t typed);
    eq_word_t predicted;
    if (src_idle_pct != 0 && $urandom_range(99, 0) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    left_sample_i <= smp;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    predicted = equalize_word(smp);
    pending_words.push_back(use_typed ? typed : predicted);
    words_sent++;
  endtask

  task automatic configure_phase(input int phase);
    logic [31:0] lo_c;
    logic [31:0] hi_c;
    logic [31:0] g_lo;
    logic [31:0] g_mid;
    logic [31:0] g_hi;
    case (phase)
      0: begin
        // bits above the coefficient width must be dropped
        lo_c = {2'b11, COEF_MAX};
        hi_c = '0;
        g_lo = GAIN_ONE; g_mid = GAIN_ONE; g_hi = GAIN_ONE;
      end
      1: begin
        lo_c = '0;
        hi_c = {2'b00, COEF_MAX};
        g_lo = GAIN_MIN; g_mid = GAIN_MAX; g_hi = GAIN_OFF;
      end
      2: begin
        lo_c = {2'b00, COEF_MAX};
        hi_c = {2'b00, COEF_MAX};
        g_lo = $urandom(); g_mid = $urandom(); g_hi = $urandom();
      end
      default: begin
        lo_c = rand_coef();
        hi_c = rand_coef();
        g_lo = rand_gain(); g_mid = rand_gain(); g_hi = rand_gain();
      end
    endcase
    // unmapped register slots must not disturb anything
    if (phase == 0) begin
      for (int i = REG_HIGH_GAIN + 1; i < 8; i++) apb_write(i[2:0], $urandom());
    end
    apb_write(REG_LOW_COEF, lo_c);
    apb_write(REG_HIGH_COEF, hi_c);
    apb_write(REG_LOW_GAIN, g_lo);
    apb_write(REG_MID_GAIN, g_mid);
    apb_write(REG_HIGH_GAIN, g_hi);
    check_regs();
  endtask

  // Result side: words are compared mid-cycle, at the falling edge before the accepting edge
  initial begin : result_sink
    eq_word_t want;
    int       hold_left;
    int       burst_left;
    bit       next_stall;
    hold_left   = 0;
    burst_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: left_out %0d clipped %0b", $signed(left_out_o), clipped_o);
          error_count++;
        end else begin
          want = pending_words.pop_front();
          words_checked++;
          if (want.clipped) clipped_seen++;
          if (left_out_o !== want.left_out) begin
            $error("left_out: expected %0d, actual %0d",
                   $signed(want.left_out), $signed(left_out_o));
            error_count++;
          end
          if (right_out_o !== want.right_out) begin
            $error("right_out: expected %0d, actual %0d",
                   $signed(want.right_out), $signed(right_out_o));
            error_count++;
          end
          if (clipped_o !== want.clipped) begin
            $error("clipped: expected %0b, actual %0b", want.clipped, clipped_o);
            error_count++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        next_stall = 1'b1;
      end else if (sink_stall_pct != 0 && $urandom_range(99, 0) < sink_stall_pct) begin
        burst_left = $urandom_range(3, 0);
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      @(posedge clk_i);
      out_stall_i <= next_stall;
    end
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] smp;
    eq_word_t    typed;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    left_sample_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    // predictor reset state
    low_coef_q  = '0;
    high_coef_q = '0;
    low_gain_q  = int'(GAIN_ONE);
    mid_gain_q  = int'(GAIN_ONE);
    high_gain_q = int'(GAIN_ONE);
    for (int b = 0; b < 2; b++)
      for (int i = 0; i < 4; i++) pole_q[b][i] = 0;
    for (int i = 0; i < 3; i++) delay_q[i] = 0;
    smp = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    check_regs();

    // Directed table, with light idling on both sides
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    for (int k = 0; k < $size(DIRECTED); k++) begin
      if (DIRECTED[k].set_gains) begin
        wait_drained();
        apb_write(REG_LOW_GAIN, DIRECTED[k].gains);
        apb_write(REG_MID_GAIN, DIRECTED[k].gains);
        apb_write(REG_HIGH_GAIN, DIRECTED[k].gains);
      end
      typed = '{DIRECTED[k].out_val, DIRECTED[k].out_val, DIRECTED[k].out_clip};
      send_sample(DIRECTED[k].sample, DIRECTED[k].known, typed);
    end

    // Random phases, each under its own coefficients and gains
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      configure_phase(phase);
      if (phase == QUIET_PHASE || phase == NUM_PHASES - 1) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end else begin
        src_idle_pct   = $urandom_range(40, 5);
        sink_stall_pct = $urandom_range(40, 5);
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // full-scale noise, quiet signal, or a held level that lets poles settle
        case ($urandom_range(9, 0))
          6, 7:    smp = 16'($urandom_range(512, 0) - 256);
          8, 9:    smp = smp;
          default: smp = 16'($urandom());
        endcase
        if (phase == HOLD_PHASE && n == HOLD_AT_WORD) hold_req = 1'b1;
        send_sample(smp, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Sent %0d sample words over %0d register settings;", words_sent, NUM_PHASES + 4);
    $display("checked %0d output words, %0d of them saturated.", words_checked, clipped_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
